/* hw/rtl/r16ae_pkg.sv */
// shared types and constants of the 16-bit alu execute stage
// instruction field layout, opcode and function codes, result record
// no dependencies
`default_nettype none

package r16ae_pkg;

  localparam int unsigned WORD_W   = 16;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_AW   = $clog2(NUM_REGS);
  localparam int unsigned OPC_W    = 4;
  localparam int unsigned FN_W     = 3;
  localparam int unsigned IMM6_W   = 6;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SHAMT_W  = 5;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [REG_AW-1:0] reg_idx_t;
  typedef logic [OPC_W-1:0]  opcode_t;
  typedef logic [FN_W-1:0]   func_t;

  // opcodes handled here
  localparam opcode_t OPC_AL   = 4'b0000;
  localparam opcode_t OPC_CMP  = 4'b0001;
  localparam opcode_t OPC_ADDI = 4'b0010;
  localparam opcode_t OPC_MOVI = 4'b1001;

  // arithmetic-logic functions
  localparam func_t FN_AND = 3'b000;
  localparam func_t FN_OR  = 3'b001;
  localparam func_t FN_XOR = 3'b010;
  localparam func_t FN_NOT = 3'b011;
  localparam func_t FN_ADD = 3'b100;
  localparam func_t FN_SUB = 3'b101;
  localparam func_t FN_SHA = 3'b110;
  localparam func_t FN_SHL = 3'b111;

  // compare functions
  localparam func_t FN_LT  = 3'b000;
  localparam func_t FN_LE  = 3'b001;
  localparam func_t FN_EQ  = 3'b011;
  localparam func_t FN_LTU = 3'b100;
  localparam func_t FN_LEU = 3'b101;

  // field positions in the instruction word
  localparam int unsigned OPC_LSB = 12;
  localparam int unsigned RA_LSB  = 9;
  localparam int unsigned RB_LSB  = 6;
  localparam int unsigned RD_LSB  = 3;
  localparam int unsigned HI_SEL_BIT = 8;

  typedef struct packed {
    logic               write_done;
    reg_idx_t           dest_index;
    logic signed [WORD_W-1:0] written_value;
    logic               ignored;
  } exec_res_t;

endpackage

`default_nettype wire

/* hw/rtl/r16ae_if.sv */
// valid/ready channel interfaces: instruction words in, write-back reports out
// depends on r16ae_pkg
`default_nettype none

interface r16ae_in_if;
  import r16ae_pkg::*;
  logic  valid;
  logic  ready;
  word_t instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

interface r16ae_out_if;
  import r16ae_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     write_done;
  reg_idx_t                 dest_index;
  logic signed [WORD_W-1:0] written_value;
  logic                     ignored;

  modport source (output valid, output write_done, output dest_index,
                  output written_value, output ignored, input ready);
  modport sink   (input valid, input write_done, input dest_index,
                  input written_value, input ignored, output ready);
endinterface

`default_nettype wire

/* hw/rtl/risc16_alu_execute_stage.sv */
// Execute stage of a 16-bit processor: decode, register-file read,
// ALU or compare operation, and write-back of one instruction word.
// Depends on r16ae_pkg, r16ae_if, r16ae_regfile, r16ae_alu.
//
// Usage:
//   in_if  (sink):   one instruction_word per transfer (valid/ready).
//   out_if (source): one write-back report per instruction: write_done,
//                    dest_index, written_value, ignored.
//   out_if.valid rises when the word leaves the input stage: the transfer
//   edge captures the word and reads both operands from the register file;
//   once the result register is free the word executes and writes back into
//   the register file and the result register together. Throughput is one
//   instruction per cycle while out_if.ready is high; each word sees every write of the words before it.
//   Reset (rst_n low, synchronous) empties both stages and makes all
//   eight registers read as zero.
//   When the receiver holds out_if.ready low, the result register keeps its
//   report and the input stage keeps one more word; in_if.ready then drops
//   until the result transfer happens. The register file is written only when
//   an instruction moves into the result register.
`default_nettype none

module risc16_alu_execute_stage (
  input  logic          clk,
  input  logic          rst_n,
  r16ae_in_if.sink      in_if,
  r16ae_out_if.source   out_if
);
  import r16ae_pkg::*;

  logic      ival_r;
  word_t     instr_r;
  logic      oval_r;
  exec_res_t ores_r;
  logic      accept;
  logic      adv;
  word_t     a_data;
  word_t     b_data;
  exec_res_t res;

  assign adv          = ival_r && (!oval_r || out_if.ready);
  assign in_if.ready  = !ival_r || adv;
  assign accept       = in_if.valid && in_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ival_r <= 1'b0;
    end else if (accept) begin
      ival_r <= 1'b1;
    end else if (adv) begin
      ival_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      instr_r <= in_if.instruction_word;
    end
  end

  r16ae_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .ra_addr (in_if.instruction_word[RA_LSB +: REG_AW]),
    .rb_addr (in_if.instruction_word[RB_LSB +: REG_AW]),
    .wr_en   (adv && res.write_done),
    .wr_addr (res.dest_index),
    .wr_data (word_t'(res.written_value)),
    .a_data  (a_data),
    .b_data  (b_data)
  );

  r16ae_alu u_alu (
    .instr (instr_r),
    .a     (a_data),
    .b     (b_data),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oval_r <= 1'b0;
    end else if (adv) begin
      oval_r <= 1'b1;
    end else if (out_if.ready) begin
      oval_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ores_r <= res;
    end
  end

  assign out_if.valid         = oval_r;
  assign out_if.write_done    = ores_r.write_done;
  assign out_if.dest_index    = ores_r.dest_index;
  assign out_if.written_value = ores_r.written_value;
  assign out_if.ignored       = ores_r.ignored;

endmodule

`default_nettype wire

/* hw/rtl/r16ae_regfile.sv */
// eight-entry register file, one write port, two registered read ports
// valid bits give the all-zero reset; same-cycle write is forwarded to reads
// depends on r16ae_pkg
`default_nettype none

module r16ae_regfile (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  r16ae_pkg::reg_idx_t ra_addr,
  input  r16ae_pkg::reg_idx_t rb_addr,
  input  logic              wr_en,
  input  r16ae_pkg::reg_idx_t wr_addr,
  input  r16ae_pkg::word_t  wr_data,
  output r16ae_pkg::word_t  a_data,
  output r16ae_pkg::word_t  b_data
);
  import r16ae_pkg::*;

  word_t               mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;
  word_t               a_data_r;
  word_t               b_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // write-first: a register written in the read cycle returns the new value
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == ra_addr)) begin
        a_data_r <= wr_data;
      end else begin
        a_data_r <= vld_r[ra_addr] ? mem[ra_addr] : '0;
      end
      if (wr_en && (wr_addr == rb_addr)) begin
        b_data_r <= wr_data;
      end else begin
        b_data_r <= vld_r[rb_addr] ? mem[rb_addr] : '0;
      end
    end
  end

  assign a_data = a_data_r;
  assign b_data = b_data_r;

endmodule

`default_nettype wire

/* hw/rtl/r16ae_alu.sv */
// decode and execute of one instruction word against its two operands
// produces the write-back record; depends on r16ae_pkg
`default_nettype none

module r16ae_alu (
  input  r16ae_pkg::word_t     instr,
  input  r16ae_pkg::word_t     a,
  input  r16ae_pkg::word_t     b,
  output r16ae_pkg::exec_res_t res
);
  import r16ae_pkg::*;

  opcode_t              opc;
  func_t                fn;
  reg_idx_t             ra;
  reg_idx_t             rb;
  reg_idx_t             rd;
  logic [SHAMT_W-1:0]   amt;
  logic [SHAMT_W-1:0]   rmag;
  logic                 sha_fill;
  word_t                shl_left;
  word_t                sha_right;
  word_t                shl_right;
  word_t                sha_val;
  word_t                shl_val;
  word_t                imm_ext;
  word_t                byte_ext;
  logic [BYTE_W-1:0]    n8;
  logic                 wr;
  reg_idx_t             dst;
  word_t                val;

  assign opc = instr[OPC_LSB +: OPC_W];
  assign ra  = instr[RA_LSB +: REG_AW];
  assign rb  = instr[RB_LSB +: REG_AW];
  assign rd  = instr[RD_LSB +: REG_AW];
  assign fn  = instr[FN_W-1:0];
  assign n8  = instr[BYTE_W-1:0];

  assign imm_ext  = {{(WORD_W-IMM6_W){instr[IMM6_W-1]}}, instr[IMM6_W-1:0]};
  assign byte_ext = {{(WORD_W-BYTE_W){n8[BYTE_W-1]}}, n8};

  // shift amount is signed: non-negative shifts left, negative shifts right
  assign amt      = b[SHAMT_W-1:0];
  assign rmag     = SHAMT_W'(~amt + 1'b1);
  assign sha_fill = a[WORD_W-1];
  assign shl_left = a << amt[SHAMT_W-2:0];
  // one extra fill bit keeps a right shift by the full width well defined
  assign sha_right = WORD_W'($signed({sha_fill, a}) >>> rmag);
  assign shl_right = WORD_W'($signed({1'b0, a}) >>> rmag);
  assign sha_val  = amt[SHAMT_W-1] ? sha_right : shl_left;
  assign shl_val  = amt[SHAMT_W-1] ? shl_right : shl_left;

  always_comb begin
    wr  = 1'b1;
    dst = rd;
    val = '0;
    unique case (opc)
      OPC_AL: begin
        case (fn)
          FN_AND:  val = a & b;
          FN_OR:   val = a | b;
          FN_XOR:  val = a ^ b;
          FN_NOT:  val = ~a;
          FN_ADD:  val = a + b;
          FN_SUB:  val = a - b;
          FN_SHA:  val = sha_val;
          default: val = shl_val;
        endcase
      end
      OPC_CMP: begin
        case (fn)
          FN_LT:   val = WORD_W'($signed(a) < $signed(b));
          FN_LE:   val = WORD_W'($signed(a) <= $signed(b));
          FN_EQ:   val = WORD_W'(a == b);
          FN_LTU:  val = WORD_W'(a < b);
          FN_LEU:  val = WORD_W'(a <= b);
          default: wr = 1'b0;
        endcase
      end
      OPC_ADDI: begin
        dst = rb;
        val = a + imm_ext;
      end
      OPC_MOVI: begin
        dst = ra;
        // high-byte move keeps the low byte of the destination
        val = instr[HI_SEL_BIT] ? {n8, a[BYTE_W-1:0]} : byte_ext;
      end
      default: wr = 1'b0;
    endcase
  end

  assign res.write_done    = wr;
  assign res.dest_index    = wr ? dst : '0;
  assign res.written_value = wr ? $signed(val) : '0;
  assign res.ignored       = ~wr;

endmodule

`default_nettype wire

/* hw/rtl/r16ae_checker.sv */
// port-level checks of the execute stage, attached by bind
// depends on r16ae_pkg and risc16_alu_execute_stage
`default_nettype none

module r16ae_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_write_done,
  input r16ae_pkg::reg_idx_t out_dest_index,
  input r16ae_pkg::word_t    out_written_value,
  input logic                out_ignored
);
  import r16ae_pkg::*;

  // a stalled result keeps valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_write_done) &&
      $stable(out_dest_index) && $stable(out_written_value) && $stable(out_ignored))
    else $error("stalled result changed");

  a_out_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_write_done != out_ignored))
    else $error("write_done and ignored not exclusive");

  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ignored |-> (out_dest_index == '0) && (out_written_value == '0))
    else $error("ignored instruction reports a write");

  // input side backs up only behind a stalled result
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output stall");

  // an accepted word reaches the output once the result register is free
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("accepted word did not advance");

endmodule

bind risc16_alu_execute_stage r16ae_checker u_r16ae_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_if.valid),
  .in_ready          (in_if.ready),
  .out_valid         (out_if.valid),
  .out_ready         (out_if.ready),
  .out_write_done    (out_if.write_done),
  .out_dest_index    (out_if.dest_index),
  .out_written_value (out_if.written_value),
  .out_ignored       (out_if.ignored)
);

`default_nettype wire
